>>> rtl/core/ilps_pkg.sv
// ilps_pkg: shared types and constants for the ignition line power sequencer
// no dependencies; used by every module of the block by scoped name

package ilps_pkg;

    localparam int unsigned IGN_W  = 10;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [IGN_W-1:0] IGNORE_RESET  = 10'd30;
    localparam logic [CNT_W-1:0] CONFIRM_RESET = 4'd5;
    localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;

    // register index taken from paddr bit 2
    localparam logic REG_IGNORE  = 1'b0;
    localparam logic REG_CONFIRM = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ASSERT  = 3'd1,
        PH_ENTER   = 3'd2,
        PH_OFF     = 3'd3,
        PH_RELEASE = 3'd4,
        PH_EXIT    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [IGN_W-1:0] ignore_ticks;
        logic [CNT_W-1:0] confirm_count;
        logic             load_ignore;
    } t_cfg;

    typedef struct packed {
        logic       line_detected;
        logic       mode_above_poweroff;
        logic       mode_is_poweroff;
    } t_tick;

    typedef struct packed {
        logic       request_poweroff;
        logic       close_modules;
        logic       open_modules;
        logic       return_previous;
        logic [2:0] phase;
    } t_result;

endpackage

>>> rtl/core/ilps_regs.sv
// ilps_regs: apb-style configuration registers (ignore_ticks, confirm_count)
// depends on ilps_pkg

module ilps_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilps_pkg::ADDR_W-1:0]   paddr,
    input  logic [ilps_pkg::DATA_W-1:0]   pwdata,
    output logic [ilps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ilps_pkg::t_cfg                o_cfg
);

    logic [ilps_pkg::IGN_W-1:0] r_ignore_ticks;
    logic [ilps_pkg::CNT_W-1:0] r_confirm_count;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_ticks  <= ilps_pkg::IGNORE_RESET;
            r_confirm_count <= ilps_pkg::CONFIRM_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                ilps_pkg::REG_IGNORE:  r_ignore_ticks  <= pwdata[ilps_pkg::IGN_W-1:0];
                ilps_pkg::REG_CONFIRM: r_confirm_count <= pwdata[ilps_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            ilps_pkg::REG_IGNORE:  prdata[ilps_pkg::IGN_W-1:0] = r_ignore_ticks;
            ilps_pkg::REG_CONFIRM: prdata[ilps_pkg::CNT_W-1:0] = r_confirm_count;
            default: ;
        endcase
    end

    // new ignore value restarts the countdown in the same cycle it is written
    assign o_cfg.ignore_ticks  = pwdata[ilps_pkg::IGN_W-1:0];
    assign o_cfg.confirm_count = r_confirm_count;
    assign o_cfg.load_ignore   = wr_en && (paddr[2] == ilps_pkg::REG_IGNORE);

endmodule

>>> rtl/core/ilps_step.sv
// ilps_step: sequencer state and the per-tick next-state and pulse logic
// depends on ilps_pkg; configuration comes from ilps_regs

module ilps_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ilps_pkg::t_tick   i_tick,
    input  ilps_pkg::t_cfg    i_cfg,
    output ilps_pkg::t_result o_result
);

    ilps_pkg::t_phase            r_phase, n_phase;
    logic [ilps_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [ilps_pkg::IGN_W-1:0]  r_ignore, n_ignore;
    logic                        r_had_higher, n_had_higher;

    logic [ilps_pkg::CNT_W-1:0]  cnt_bump;
    logic                        confirmed;
    logic                        ignoring;

    assign ignoring  = (r_ignore != '0);
    assign cnt_bump  = (r_cnt == ilps_pkg::CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign confirmed = (cnt_bump >= i_cfg.confirm_count);

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_had_higher = r_had_higher;
        n_ignore     = r_ignore;
        if (ignoring) begin
            n_ignore = r_ignore - 1'b1;
        end else begin
            unique case (r_phase)
                ilps_pkg::PH_ASSERT: begin
                    if (i_tick.line_detected) begin
                        n_cnt = cnt_bump;
                        if (confirmed) begin
                            n_phase      = ilps_pkg::PH_ENTER;
                            n_had_higher = i_tick.mode_above_poweroff;
                        end
                    end else begin
                        n_cnt   = '0;
                        n_phase = ilps_pkg::PH_IDLE;
                    end
                end
                ilps_pkg::PH_ENTER: begin
                    if (i_tick.mode_is_poweroff) begin
                        n_cnt   = '0;
                        n_phase = ilps_pkg::PH_OFF;
                    end
                end
                ilps_pkg::PH_OFF: begin
                    if (!i_tick.line_detected) n_phase = ilps_pkg::PH_RELEASE;
                end
                ilps_pkg::PH_RELEASE: begin
                    if (!i_tick.line_detected) begin
                        n_cnt = cnt_bump;
                        if (confirmed) begin
                            n_cnt   = '0;
                            n_phase = ilps_pkg::PH_EXIT;
                        end
                    end else begin
                        n_cnt   = '0;
                        n_phase = ilps_pkg::PH_OFF;
                    end
                end
                ilps_pkg::PH_EXIT: begin
                    n_had_higher = 1'b0;
                    n_phase      = ilps_pkg::PH_IDLE;
                end
                // idle and the unused codes
                default: begin
                    n_phase = i_tick.line_detected ? ilps_pkg::PH_ASSERT : ilps_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // pulse outputs
    always_comb begin
        o_result                  = '0;
        o_result.phase            = n_phase;
        if (!ignoring) begin
            unique case (r_phase)
                ilps_pkg::PH_ASSERT:
                    o_result.request_poweroff = i_tick.line_detected && confirmed
                                                && i_tick.mode_above_poweroff;
                ilps_pkg::PH_ENTER:
                    o_result.close_modules    = i_tick.mode_is_poweroff;
                ilps_pkg::PH_RELEASE:
                    o_result.open_modules     = !i_tick.line_detected && confirmed;
                ilps_pkg::PH_EXIT:
                    o_result.return_previous  = r_had_higher;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ilps_pkg::PH_IDLE;
            r_cnt        <= '0;
            r_ignore     <= ilps_pkg::IGNORE_RESET;
            r_had_higher <= 1'b0;
        end else if (i_cfg.load_ignore) begin
            r_ignore <= i_cfg.ignore_ticks;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_ignore     <= n_ignore;
            r_had_higher <= n_had_higher;
        end
    end

endmodule

>>> rtl/core/ignition_line_power_sequencer.sv
// ignition_line_power_sequencer: top level, input handshake and result register
// depends on ilps_pkg, ilps_regs and ilps_step
//
// usage: one input beat per 100 ms tick carries the line detect level and two
// mode facts; one result beat comes back per input beat with four one-beat
// action pulses and the phase reached after that tick.
// channels: input (i_in_valid / o_in_ready), result (o_out_valid / i_out_ready),
// plus an apb-style register port (ignore_ticks at 0x0, confirm_count at 0x4).
// the result of a beat sits in the result register in the cycle after it is
// accepted. throughput: one beat per cycle while i_out_ready is high, set
// by the single result register; the tick logic is one pass of next-state logic.
// stall: while a result waits and i_out_ready is low, o_in_ready is low and
// the result holds; a beat is taken in the same cycle the result drains.
// reset: phase idle, counters cleared, ignore countdown reloaded to 30,
// registers back to their defaults, no result pending.
// writing ignore_ticks restarts the ignore period at once.

module ignition_line_power_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ilps_pkg::ADDR_W-1:0] paddr,
    input  logic [ilps_pkg::DATA_W-1:0] pwdata,
    output logic [ilps_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_line_detected,
    input  logic                        i_mode_above_poweroff,
    input  logic                        i_mode_is_poweroff,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_request_poweroff,
    output logic                        o_close_modules,
    output logic                        o_open_modules,
    output logic                        o_return_previous,
    output logic [2:0]                  o_phase
);

    ilps_pkg::t_cfg    cfg;
    ilps_pkg::t_tick   tick;
    ilps_pkg::t_result result;
    ilps_pkg::t_result r_result;
    logic              r_out_valid;
    logic              accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign tick.line_detected       = i_line_detected;
    assign tick.mode_above_poweroff = i_mode_above_poweroff;
    assign tick.mode_is_poweroff    = i_mode_is_poweroff;

    ilps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ilps_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_tick   (tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_request_poweroff = r_result.request_poweroff;
    assign o_close_modules    = r_result.close_modules;
    assign o_open_modules     = r_result.open_modules;
    assign o_return_previous  = r_result.return_previous;
    assign o_phase            = r_result.phase;

endmodule

>>> rtl/core/ilps_checker.sv
// ilps_checker: port-level assertions for the ignition line power sequencer
// depends on ilps_pkg; attached to the top level by the bind below

module ilps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_request_poweroff,
    input logic       o_close_modules,
    input logic       o_open_modules,
    input logic       o_return_previous,
    input logic [2:0] o_phase
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // actions are mutually exclusive in one beat
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_request_poweroff, o_close_modules,
                                  o_open_modules, o_return_previous}))
        else $error("more than one action pulse in a beat");

    // each action lands in the phase it leads to
    a_action_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_request_poweroff || o_phase == ilps_pkg::PH_ENTER)
                     && (!o_close_modules    || o_phase == ilps_pkg::PH_OFF)
                     && (!o_open_modules     || o_phase == ilps_pkg::PH_EXIT)
                     && (!o_return_previous  || o_phase == ilps_pkg::PH_IDLE))
        else $error("action pulse with wrong phase");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_phase <= ilps_pkg::PH_EXIT)
        else $error("phase code out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_phase))
        else $error("stalled result changed");

endmodule

bind ignition_line_power_sequencer ilps_checker u_ilps_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_request_poweroff (o_request_poweroff),
    .o_close_modules    (o_close_modules),
    .o_open_modules     (o_open_modules),
    .o_return_previous  (o_return_previous),
    .o_phase            (o_phase)
);

>>> bench/tb.sv
// tb: self-checking bench for ignition_line_power_sequencer, directed table then random ticks
// depends on ilps_pkg and the rtl; predicts every result beat, checks register readback

module tb;
    import ilps_pkg::*;

    localparam int HOLD_CYCLES = 50;
    localparam int N_IGNORE_ROWS = 2;
    localparam int N_ROWS = 26;

    typedef struct packed {
        t_tick   tick;
        logic    typed;
        t_result want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_line_detected = 1'b0;
    logic                i_mode_above_poweroff = 1'b0;
    logic                i_mode_is_poweroff = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b1;
    logic                o_request_poweroff;
    logic                o_close_modules;
    logic                o_open_modules;
    logic                o_return_previous;
    logic [2:0]          o_phase;

    // typed expectation travels with the beat it belongs to
    logic                row_typed = 1'b0;
    t_result             row_want = '0;

    // predictor state and its copy of the registers
    logic [IGN_W-1:0]    m_ignore_left = IGNORE_RESET;
    logic [CNT_W-1:0]    m_confirm = CONFIRM_RESET;
    logic [CNT_W-1:0]    m_count = '0;
    t_phase              m_phase = PH_IDLE;
    logic                m_had_higher = 1'b0;

    t_result             expected_actions[$];
    int                  failures = 0;
    bit                  gaps_on = 1'b1;
    bit                  stalls_on = 1'b1;
    bit                  hold_off_req = 1'b0;
    bit                  line_level = 1'b0;
    int                  line_run_left = 0;

    t_stim_row directed_rows [N_ROWS] = '{
        // inside the reset ignore period
        '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},
        '{'{1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},
        // ignore period of 2 restarted by the write, confirm count 2
        '{'{1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},
        '{'{1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},
        '{'{1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_ASSERT}},
        '{'{1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, PH_ENTER}},
        '{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, PH_OFF}},
        '{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
        // line comes back mid release check, count must restart
        '{'{1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, PH_EXIT}},
        '{'{1'b0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, PH_IDLE}},
        // failed assert check, then a cycle entered from a low mode
        '{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, PH_OFF}},
        '{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, PH_EXIT}},
        '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}}
    };

    ignition_line_power_sequencer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_line_detected       (i_line_detected),
        .i_mode_above_poweroff (i_mode_above_poweroff),
        .i_mode_is_poweroff    (i_mode_is_poweroff),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_request_poweroff    (o_request_poweroff),
        .o_close_modules       (o_close_modules),
        .o_open_modules        (o_open_modules),
        .o_return_previous     (o_return_previous),
        .o_phase               (o_phase)
    );

    always #1 i_clk = ~i_clk;

    // one tick of the sequencer: advances the predicted state, returns the action beat
    function automatic t_result next_actions(t_tick t);
        t_result r;
        r = '0;
        if (m_ignore_left != '0) begin
            m_ignore_left = m_ignore_left - 1'b1;
        end else begin
            case (m_phase)
                PH_ASSERT: begin
                    if (t.line_detected) begin
                        if (m_count != CNT_MAX) m_count = m_count + 1'b1;
                        if (m_count >= m_confirm) begin
                            m_phase = PH_ENTER;
                            m_had_higher = t.mode_above_poweroff;
                            r.request_poweroff = t.mode_above_poweroff;
                        end
                    end else begin
                        m_count = '0;
                        m_phase = PH_IDLE;
                    end
                end
                PH_ENTER: begin
                    if (t.mode_is_poweroff) begin
                        m_count = '0;
                        r.close_modules = 1'b1;
                        m_phase = PH_OFF;
                    end
                end
                PH_OFF: begin
                    if (!t.line_detected) m_phase = PH_RELEASE;
                end
                PH_RELEASE: begin
                    if (!t.line_detected) begin
                        if (m_count != CNT_MAX) m_count = m_count + 1'b1;
                        if (m_count >= m_confirm) begin
                            m_count = '0;
                            r.open_modules = 1'b1;
                            m_phase = PH_EXIT;
                        end
                    end else begin
                        m_count = '0;
                        m_phase = PH_OFF;
                    end
                end
                PH_EXIT: begin
                    r.return_previous = m_had_higher;
                    m_had_higher = 1'b0;
                    m_phase = PH_IDLE;
                end
                default: begin
                    m_phase = t.line_detected ? PH_ASSERT : PH_IDLE;
                end
            endcase
        end
        r.phase = m_phase;
        return r;
    endfunction

    function automatic void note_failure(string what, t_result want, t_result got);
        if (failures < 10) begin
            $display("tb: mismatch, %s: expected req=%0b cls=%0b opn=%0b ret=%0b phase=%0d",
                     what, want.request_poweroff, want.close_modules, want.open_modules,
                     want.return_previous, want.phase);
            $display("tb:   got req=%0b cls=%0b opn=%0b ret=%0b phase=%0d",
                     got.request_poweroff, got.close_modules, got.open_modules,
                     got.return_previous, got.phase);
        end
        failures++;
    endfunction

    // result beats against the oldest expectation, then predict the beat taken at this edge
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        t_result predicted;
        t_tick   tick;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_request_poweroff, o_close_modules, o_open_modules,
                        o_return_previous, o_phase};
                if (expected_actions.size() == 0) begin
                    note_failure("result beat with nothing expected", '0, got);
                end else begin
                    want = expected_actions.pop_front();
                    if (got.request_poweroff !== want.request_poweroff ||
                        got.close_modules !== want.close_modules ||
                        got.open_modules !== want.open_modules ||
                        got.return_previous !== want.return_previous ||
                        got.phase !== want.phase)
                        note_failure("result beat", want, got);
                end
            end
            if (i_in_valid && o_in_ready) begin
                tick = '{i_line_detected, i_mode_above_poweroff, i_mode_is_poweroff};
                predicted = next_actions(tick);
                expected_actions.push_back(row_typed ? row_want : predicted);
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 7);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #200000;
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_tick(input t_tick t, input logic typed, input t_result want);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_line_detected <= t.line_detected;
        i_mode_above_poweroff <= t.mode_above_poweroff;
        i_mode_is_poweroff <= t.mode_is_poweroff;
        row_typed <= typed;
        row_want <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_actions.size() != 0) @(posedge i_clk);
    endtask

    // write then read back; junk in the upper data bits must not stick
    task automatic write_reg(input logic idx, input logic [IGN_W-1:0] field);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] want;
        if (idx == REG_IGNORE) begin
            want = DATA_W'(field);
            word = ($urandom() << IGN_W) | want;
        end else begin
            want = DATA_W'(field[CNT_W-1:0]);
            word = ($urandom() << CNT_W) | want;
        end
        wait_drained();
        repeat (3) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the write here, readback setup follows at once
        if (idx == REG_IGNORE) begin
            m_ignore_left = field;
        end else begin
            m_confirm = field[CNT_W-1:0];
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            if (failures < 10)
                $display("tb: mismatch, register at 0x%0h: expected 0x%0h, got 0x%0h",
                         {idx, 2'b00}, want, prdata);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // line held in runs, mostly long enough to pass a check, with some noise
    function automatic t_tick random_tick();
        t_tick       t;
        logic [2:0]  noise;
        if (line_run_left == 0) begin
            line_level = !line_level;
            if ($urandom_range(0, 9) < 7)
                line_run_left = $urandom_range(m_confirm + 1, m_confirm + 6);
            else
                line_run_left = $urandom_range(1, m_confirm + 1);
        end
        line_run_left--;
        t.line_detected = line_level;
        t.mode_above_poweroff = 1'($urandom_range(0, 1));
        if (m_phase == PH_ENTER)
            t.mode_is_poweroff = ($urandom_range(0, 2) == 0);
        else
            t.mode_is_poweroff = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
            noise = 3'($urandom_range(0, 7));
            t = noise;
        end
        return t;
    endfunction

    task automatic run_random(input int n, input bit idle_ok);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                gaps_on = idle_ok && ($urandom_range(0, 2) != 0);
                stalls_on = idle_ok && ($urandom_range(0, 2) != 0);
            end
            send_tick(random_tick(), 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (r == N_IGNORE_ROWS) begin
                write_reg(REG_IGNORE, 10'd2);
                write_reg(REG_CONFIRM, 10'd2);
            end
            send_tick(directed_rows[r].tick, directed_rows[r].typed, directed_rows[r].want);
        end

        write_reg(REG_IGNORE, 10'd0);
        write_reg(REG_CONFIRM, IGN_W'(CNT_MAX));
        run_random(100, 1'b1);

        write_reg(REG_IGNORE, 10'd5);
        write_reg(REG_CONFIRM, 10'd1);
        run_random(60, 1'b1);
        // long result hold-off while ticks keep coming, then a full drain
        hold_off_req = 1'b1;
        run_random(30, 1'b1);
        wait_drained();
        run_random(40, 1'b1);

        // zero count: first qualifying tick accepts
        write_reg(REG_IGNORE, 10'd0);
        write_reg(REG_CONFIRM, 10'd0);
        run_random(50, 1'b1);

        // widest ignore value, then a shorter one written over it
        write_reg(REG_CONFIRM, 10'd3);
        write_reg(REG_IGNORE, 10'h3ff);
        run_random(20, 1'b1);
        write_reg(REG_IGNORE, 10'd40);
        run_random(120, 1'b1);

        write_reg(REG_IGNORE, IGN_W'($urandom_range(0, 20)));
        write_reg(REG_CONFIRM, IGN_W'($urandom_range(2, 14)));
        run_random(150, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0 && expected_actions.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
